/* rtl/core/fblr_pkg.sv */
// Shared types and codes for the frame buffer line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package fblr_pkg;

  // Widths fixed by the channel payloads
  localparam int PORT_COORD_W = 12;
  localparam int COLOR_W      = 32;
  localparam int ADDR_W       = 32;
  localparam int PITCH_W      = 14;
  localparam int BYTES_W      = 3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 2'd2;

  // Input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef struct packed {
    logic                    opcode;
    logic [PORT_COORD_W-1:0] start_x;
    logic [PORT_COORD_W-1:0] start_y;
    logic [PORT_COORD_W-1:0] finish_x;
    logic [PORT_COORD_W-1:0] finish_y;
    logic [COLOR_W-1:0]      draw_color;
  } fblr_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       write_address;
    logic [COLOR_W-1:0]      write_data;
    logic [BYTES_W-1:0]      write_bytes;
    logic [PORT_COORD_W-1:0] pixel_x;
    logic [PORT_COORD_W-1:0] pixel_y;
    logic                    last_pixel;
  } fblr_out_t;

  // Byte address, data and byte count of one pixel store
  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [COLOR_W-1:0] data;
    logic [BYTES_W-1:0] bytes;
  } fblr_store_t;

endpackage

`default_nettype wire

/* rtl/core/fblr_pixel_out.sv */
// Pixel store formatter: byte address, masked colour and byte count.
`timescale 1ns / 1ps
`default_nettype none

module fblr_pixel_out #(
  parameter int COORD_BITS = 12
) (
  input  wire logic [fblr_pkg::BYTES_W-1:0] pixel_bytes,
  input  wire logic [fblr_pkg::ADDR_W-1:0]  row_address,
  input  wire logic [COORD_BITS-1:0]        cur_x,
  input  wire logic [fblr_pkg::COLOR_W-1:0] line_color,
  output fblr_pkg::fblr_store_t             store
);

  localparam int AddrW = fblr_pkg::ADDR_W;
  localparam int OffW  = COORD_BITS + 2;

  logic [fblr_pkg::BYTES_W-1:0] nb;
  logic [OffW-1:0]              x_off;
  logic [fblr_pkg::COLOR_W-1:0] mask;

  always_comb begin
    // Sizes of zero act as one byte, anything above four as four
    if (pixel_bytes == 3'd0) begin
      nb = 3'd1;
    end else if (pixel_bytes > 3'd4) begin
      nb = 3'd4;
    end else begin
      nb = pixel_bytes;
    end

    case (nb)
      3'd1: begin
        x_off = {2'b00, cur_x};
        mask  = 32'h0000_00FF;
      end
      3'd2: begin
        x_off = {1'b0, cur_x, 1'b0};
        mask  = 32'h0000_FFFF;
      end
      3'd3: begin
        x_off = {1'b0, cur_x, 1'b0} + {2'b00, cur_x};
        mask  = 32'h00FF_FFFF;
      end
      default: begin
        x_off = {cur_x, 2'b00};
        mask  = 32'hFFFF_FFFF;
      end
    endcase

    store.address = row_address + AddrW'(x_off);
    store.data    = line_color & mask;
    store.bytes   = nb;
  end

endmodule

`default_nettype wire

/* rtl/core/framebuffer_line_rasterizer.sv */
// Bresenham line rasterizer producing pixel stores for a linear frame buffer.
//
// Usage: send a start item (opcode 0) with both endpoints and the colour,
// then one step item (opcode 1) per pixel. Each step while a line is active
// returns one pixel store; the store at the second endpoint carries
// last_pixel and ends the line. Start items and steps while idle return
// nothing. A start during a line drops it and begins the new one.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low. Items pass an input register, then the stepping stage that
// updates the line state and loads the output register. One item per cycle is
// sustained while the receiver does not stall; the Bresenham update (an add, a
// compare and a select) is combinational. When the receiver stalls the output
// register holds its store and a full input register raises in_stall; an empty
// input register still takes one more item first. Reset (rst, synchronous)
// empties both registers, ends any line and restores frame_base 0, row_pitch
// 640 and pixel_bytes 1. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata; the user must do so only while idle (unchecked).
`timescale 1ns / 1ps
`default_nettype none

module framebuffer_line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [fblr_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [fblr_pkg::ADDR_W-1:0]    cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire fblr_pkg::fblr_in_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output fblr_pkg::fblr_out_t                 out_data
);

  localparam int PortW  = fblr_pkg::PORT_COORD_W;
  localparam int AddrW  = fblr_pkg::ADDR_W;
  localparam int PitchW = fblr_pkg::PITCH_W;
  localparam int TdW    = COORD_BITS + 1;
  localparam int ErrW   = COORD_BITS + 3;
  localparam int ProdW  = COORD_BITS + PitchW;

  // Configuration registers
  logic [AddrW-1:0]             frame_base;
  logic [PitchW-1:0]            row_pitch;
  logic [fblr_pkg::BYTES_W-1:0] pixel_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base  <= '0;
      row_pitch   <= 14'd640;
      pixel_bytes <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        fblr_pkg::CFG_FRAME_BASE:  frame_base  <= cfg_wdata;
        fblr_pkg::CFG_ROW_PITCH:   row_pitch   <= cfg_wdata[PitchW-1:0];
        fblr_pkg::CFG_PIXEL_BYTES: pixel_bytes <= cfg_wdata[fblr_pkg::BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                  s1_valid;
  logic                  s1_opcode;
  logic [COORD_BITS-1:0] s1_x1, s1_y1, s1_x2, s1_y2;
  logic [31:0]           s1_color;
  logic [ProdW-1:0]      s1_row_off;
  logic                  advance;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_opcode  <= in_data.opcode;
      s1_x1      <= COORD_BITS'(in_data.start_x);
      s1_y1      <= COORD_BITS'(in_data.start_y);
      s1_x2      <= COORD_BITS'(in_data.finish_x);
      s1_y2      <= COORD_BITS'(in_data.finish_y);
      s1_color   <= in_data.draw_color;
      // Start row offset; user must keep pitch stable while items are in flight
      s1_row_off <= COORD_BITS'(in_data.start_y) * row_pitch;
    end
  end

  // Line state
  logic                    busy;
  logic                    x_major;
  logic [COORD_BITS-1:0]   cur_x, cur_y, end_x, end_y;
  logic [TdW-1:0]          twice_dx, twice_dy;
  logic signed [1:0]       step_x, step_y;
  logic signed [ErrW-1:0]  error_term;
  logic [AddrW-1:0]        row_address;
  logic [31:0]             line_color;

  // Start setup
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0]      abs_dx, abs_dy;
  logic                       new_x_major;
  logic signed [ErrW-1:0]     new_error;

  always_comb begin
    dx     = $signed({1'b0, s1_x2}) - $signed({1'b0, s1_x1});
    dy     = $signed({1'b0, s1_y2}) - $signed({1'b0, s1_y1});
    abs_dx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    abs_dy = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    new_x_major = abs_dx > abs_dy;
    if (new_x_major) begin
      new_error = $signed({2'b00, abs_dy, 1'b0}) - $signed({3'b000, abs_dx});
    end else begin
      new_error = $signed({2'b00, abs_dx, 1'b0}) - $signed({3'b000, abs_dy});
    end
  end

  function automatic logic signed [1:0] sign_of(input logic signed [COORD_BITS:0] v);
    logic signed [1:0] s;
    if (v == '0) begin
      s = 2'sb00;
    end else if (v[COORD_BITS]) begin
      s = 2'sb11;
    end else begin
      s = 2'sb01;
    end
    return s;
  endfunction

  // Bresenham advance
  logic                   last;
  logic                   err_ge;
  logic                   do_row, do_col;
  logic signed [ErrW-1:0] tdx_s, tdy_s;
  logic signed [ErrW-1:0] error_term_next;
  logic [COORD_BITS-1:0]  cur_x_next, cur_y_next;
  logic [AddrW-1:0]       row_address_next;

  always_comb begin
    last   = x_major ? (cur_x == end_x) : (cur_y == end_y);
    err_ge = !error_term[ErrW-1];
    tdx_s  = $signed({2'b00, twice_dx});
    tdy_s  = $signed({2'b00, twice_dy});
    do_row = x_major ? err_ge : 1'b1;
    do_col = x_major ? 1'b1 : err_ge;
    if (x_major) begin
      error_term_next = error_term + tdy_s - (err_ge ? tdx_s : '0);
    end else begin
      error_term_next = error_term + tdx_s - (err_ge ? tdy_s : '0);
    end

    cur_x_next = cur_x;
    if (do_col) begin
      cur_x_next = cur_x + {{(COORD_BITS-2){step_x[1]}}, step_x};
    end

    cur_y_next       = cur_y;
    row_address_next = row_address;
    if (do_row) begin
      cur_y_next = cur_y + {{(COORD_BITS-2){step_y[1]}}, step_y};
      if (step_y == 2'sb01) begin
        row_address_next = row_address + AddrW'(row_pitch);
      end else if (step_y == 2'sb11) begin
        row_address_next = row_address - AddrW'(row_pitch);
      end
    end
  end

  logic is_start, is_emit;
  assign is_start = advance && (s1_opcode == fblr_pkg::OP_START);
  assign is_emit  = advance && (s1_opcode == fblr_pkg::OP_STEP) && busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (is_start) begin
      busy <= 1'b1;
    end else if (is_emit && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_start) begin
      x_major     <= new_x_major;
      cur_x       <= s1_x1;
      cur_y       <= s1_y1;
      end_x       <= s1_x2;
      end_y       <= s1_y2;
      twice_dx    <= {abs_dx, 1'b0};
      twice_dy    <= {abs_dy, 1'b0};
      step_x      <= sign_of(dx);
      step_y      <= sign_of(dy);
      error_term  <= new_error;
      row_address <= frame_base + AddrW'(s1_row_off);
      line_color  <= s1_color;
    end else if (is_emit && !last) begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      error_term  <= error_term_next;
      row_address <= row_address_next;
    end
  end

  // Output register
  fblr_pkg::fblr_store_t store;

  fblr_pixel_out #(
    .COORD_BITS (COORD_BITS)
  ) u_pixel_out (
    .pixel_bytes (pixel_bytes),
    .row_address (row_address),
    .cur_x       (cur_x),
    .line_color  (line_color),
    .store       (store)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= is_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (is_emit) begin
      out_data.write_address <= store.address;
      out_data.write_data    <= store.data;
      out_data.write_bytes   <= store.bytes;
      out_data.pixel_x       <= PortW'(cur_x);
      out_data.pixel_y       <= PortW'(cur_y);
      out_data.last_pixel    <= last;
    end
  end

`ifndef SYNTHESIS
  // The input side only holds off while a finished store is blocked downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked output");

  // A start item never yields a store
  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    (is_start && !out_valid) |=> !out_valid)
    else $error("store produced by a start item");

  // An x-major line has the strictly larger doubled delta; ties go to y-major
  a_major_axis: assert property (@(posedge clk) disable iff (rst)
    (busy && x_major) |-> (twice_dx > twice_dy))
    else $error("x-major line without the larger x delta");

  // A finished line leaves the stepping stage idle unless restarted
  a_line_end: assert property (@(posedge clk) disable iff (rst)
    (is_emit && last) |=> !busy)
    else $error("line still active after its last pixel");
`endif

endmodule

`default_nettype wire
